@@ rtl/hrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types, constants and lookup functions for the reading converter.
// ----------------------------------------------------------------------------
package hrc_pkg;

  typedef enum logic [1:0] {
    CMD_TEMP  = 2'd0,
    CMD_VOLT  = 2'd1,
    CMD_FAN8  = 2'd2,
    CMD_FAN16 = 2'd3
  } cmd_e;

  localparam int REF_W       = 13;
  localparam int VALUE_W     = 31;
  localparam int DVS_W       = 17;   // divisor: up to twice a 16-bit count
  localparam int QUO_W       = 21;   // quotient bits of the constant dividend
  localparam int DIV_STEPS   = 3;    // quotient bits per divider stage
  localparam int DIV_STAGES  = QUO_W / DIV_STEPS;
  localparam int NUM_STAGES  = DIV_STAGES + 2;  // decode + divider + output
  localparam int MULA_W      = 14;
  localparam int FACT_W      = 13;

  localparam logic [REF_W-1:0] REF_RESET = 13'd4096;
  localparam logic [QUO_W-1:0] DIVIDEND  = 21'd1350000;
  localparam logic [31:0]      TEMP_MUL  = 32'd1000000;
  localparam logic [31:0]      TEMP_OFS  = 32'd273150000;
  localparam logic [31:0]      REF_MUL   = 32'd1000;

  // Decoded request, held in the first stage
  typedef struct packed {
    logic                     is_fan;
    logic                     div_run;
    logic [DVS_W-1:0]         divisor;
    logic signed [MULA_W-1:0] mul_a;
    logic [FACT_W-1:0]        factor;
    logic                     is_temp;
    logic                     neg;
    logic                     invalid;
    logic [7:0]               ndiv;
    logic                     dwrite;
  } dec_t;

  // Fields that travel alongside the arithmetic
  typedef struct packed {
    logic       is_fan;
    logic       div_run;
    logic       invalid;
    logic [7:0] ndiv;
    logic       dwrite;
  } side_t;

  // Resistor factor divided by ten; every factor is a multiple of ten
  function automatic logic [FACT_W-1:0] volt_factor(input logic [3:0] ch);
    logic [FACT_W-1:0] f;
    unique case (ch)
      4'd3, 4'd7: f = 13'd1680;
      4'd4:       f = 13'd4000;
      4'd5:       f = 13'd3100;
      4'd6:       f = 13'd5150;
      default:    f = 13'd1000;
    endcase
    return f;
  endfunction

endpackage

@@ rtl/hrc_flow.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_flow
// Valid bits and per-stage load enables; bubbles collapse under stall.
// ----------------------------------------------------------------------------
module hrc_flow (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          out_stall_i,
  output logic [hrc_pkg::NUM_STAGES-1:0] en_o,
  output logic                          in_stall_o,
  output logic                          out_valid_o
);
  import hrc_pkg::*;

  logic [NUM_STAGES-1:0] valid_q, valid_d;

  // A stage loads when it is empty or the stage after it loads
  always_comb begin
    en_o[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en_o[k] = !valid_q[k] || en_o[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en_o[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en_o[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !en_o[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

endmodule

@@ rtl/hrc_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_decode
// First stage: sort the request by kind, build divisor and multiplier inputs.
// ----------------------------------------------------------------------------
module hrc_decode (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [1:0]                 command_i,
  input  logic [3:0]                 channel_i,
  input  logic [15:0]                raw_count_i,
  input  logic [7:0]                 divisor_byte_i,
  input  logic                       wide_count_i,
  input  logic [hrc_pkg::REF_W-1:0]  ref_mv_i,
  output hrc_pkg::dec_t              dec_o
);
  import hrc_pkg::*;

  dec_t        dec_d, dec_q;
  logic [7:0]  lo;
  logic [2:0]  shift;
  logic [15:0] cnt;
  logic [15:0] sat;
  logic [DVS_W-1:0] lo_ext;

  assign lo     = raw_count_i[7:0];
  assign lo_ext = {{(DVS_W-8){1'b0}}, lo};

  always_comb begin
    dec_d         = '0;
    dec_d.ndiv    = divisor_byte_i;
    shift         = '0;
    cnt           = wide_count_i ? raw_count_i : {8'h00, lo};
    sat           = wide_count_i ? 16'hffff : 16'h00ff;
    unique case (channel_i)
      4'd0:    shift = divisor_byte_i[2:0];
      4'd1:    shift = divisor_byte_i[5:3];
      default: shift = divisor_byte_i[6] ? 3'd3 : 3'd1;
    endcase
    unique case (cmd_e'(command_i))
      CMD_TEMP: begin
        dec_d.is_temp = 1'b1;
        dec_d.mul_a   = $signed({6'b0, lo});
      end
      CMD_VOLT: begin
        if (channel_i <= 4'd8) begin
          dec_d.neg    = (channel_i == 4'd5) || (channel_i == 4'd6);
          dec_d.factor = volt_factor(channel_i);
          dec_d.mul_a  = $signed({2'b00, lo, 4'b0000} -
                                 (dec_d.neg ? {1'b0, ref_mv_i} : 14'd0));
        end
      end
      CMD_FAN8: begin
        dec_d.is_fan = 1'b1;
        if (channel_i <= 4'd2) begin
          if (lo == 8'hff) begin
            dec_d.invalid = 1'b1;
            unique case (channel_i)
              4'd0:    dec_d.ndiv = {divisor_byte_i[7:3], divisor_byte_i[2:0] + 3'd1};
              4'd1:    dec_d.ndiv = {divisor_byte_i[7:6], divisor_byte_i[5:3] + 3'd1,
                                     divisor_byte_i[2:0]};
              default: dec_d.ndiv = divisor_byte_i ^ 8'h40;
            endcase
          end else if (lo != 8'h00) begin
            dec_d.div_run = 1'b1;
            dec_d.divisor = lo_ext << shift;
          end
        end
      end
      CMD_FAN16: begin
        dec_d.is_fan = 1'b1;
        if (channel_i <= 4'd2) begin
          if (cnt == sat) begin
            dec_d.invalid = 1'b1;
          end else if (cnt != 16'h0000) begin
            // 675000 / cnt is the same as 1350000 / (2 * cnt)
            dec_d.div_run = 1'b1;
            dec_d.divisor = {cnt, 1'b0};
          end
        end
      end
    endcase
    dec_d.dwrite = (dec_d.ndiv != divisor_byte_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
    end
  end

  assign dec_o = dec_q;

endmodule

@@ rtl/hrc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_div
// Pipelined restoring divider of the constant 1350000 by a 17-bit divisor.
// ----------------------------------------------------------------------------
module hrc_div (
  input  logic                            clk_i,
  input  logic [hrc_pkg::DIV_STAGES-1:0]  en_i,
  input  logic [hrc_pkg::DVS_W-1:0]       divisor_i,
  output logic [hrc_pkg::QUO_W-1:0]       quotient_o
);
  import hrc_pkg::*;

  logic [DVS_W-1:0] rem_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];
  logic [DVS_W-1:0] dvs_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DVS_W-1:0] rem_in, rem_d, dvs_in;
    logic [QUO_W-1:0] quo_in, quo_d;
    logic [DVS_W:0]   trial;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign dvs_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign dvs_in = dvs_q[s-1];
    end

    // Shift in one dividend bit per step and subtract where the divisor fits
    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      trial = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial = {rem_d, DIVIDEND[QUO_W - 1 - s * DIV_STEPS - k]};
        if (trial >= {1'b0, dvs_in}) begin
          trial = trial - {1'b0, dvs_in};
          quo_d = {quo_d[QUO_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[QUO_W-2:0], 1'b0};
        end
        rem_d = trial[DVS_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        dvs_q[s] <= dvs_in;
      end
    end
  end

  assign quotient_o = quo_q[DIV_STAGES-1];

endmodule

@@ rtl/hrc_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_scale
// Multiply-add for temperature and voltage, delayed to match the divider.
// ----------------------------------------------------------------------------
module hrc_scale (
  input  logic                            clk_i,
  input  logic [hrc_pkg::DIV_STAGES-1:0]  en_i,
  input  hrc_pkg::dec_t                   dec_i,
  input  logic [hrc_pkg::REF_W-1:0]       ref_mv_i,
  output logic signed [hrc_pkg::VALUE_W-1:0] value_o
);
  import hrc_pkg::*;

  logic signed [20:0] mul_b;
  logic signed [34:0] prod_full;
  logic signed [31:0] prod_q;
  logic [31:0]        addc_d, addc_q;
  logic [31:0]        sum;
  logic signed [VALUE_W-1:0] line_q [1:DIV_STAGES-1];

  assign mul_b     = dec_i.is_temp ? 21'sd1000000 : $signed({8'b0, dec_i.factor});
  assign prod_full = dec_i.mul_a * mul_b;

  always_comb begin
    if (dec_i.is_temp) begin
      addc_d = TEMP_OFS;
    end else if (dec_i.neg) begin
      addc_d = 32'(ref_mv_i) * REF_MUL;
    end else begin
      addc_d = '0;
    end
  end

  assign sum = prod_q + addc_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_full[31:0];
      addc_q <= addc_d;
    end
    if (en_i[1]) begin
      line_q[1] <= $signed(sum[VALUE_W-1:0]);
    end
    for (int k = 2; k < DIV_STAGES; k++) begin
      if (en_i[k]) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  assign value_o = line_q[DIV_STAGES-1];

endmodule

@@ rtl/hwmon_reading_converter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwmon_reading_converter_top
// Raw sensor reading to microkelvin, microvolts or rpm, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while out_stall_i is low; the divider is
//   7 stages of 3 quotient bits each, one decode stage before it and the
//   output register after it.
// Reset: all stage valid bits clear; reference_mv returns to 4096 mV.
// Stall: a stalled output holds; empty stages ahead of it keep filling.
// ----------------------------------------------------------------------------
module hwmon_reading_converter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        command_i,
  input  logic [3:0]                        channel_i,
  input  logic [15:0]                       raw_count_i,
  input  logic [7:0]                        divisor_byte_i,
  input  logic                              wide_count_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [hrc_pkg::VALUE_W-1:0] value_o,
  output logic                              invalid_o,
  output logic [7:0]                        new_divisor_byte_o,
  output logic                              divisor_write_o,
  // reference voltage register write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hrc_pkg::REF_W-1:0]         cfg_data_i
);
  import hrc_pkg::*;

  logic [NUM_STAGES-1:0]      en;
  logic [REF_W-1:0]           ref_q;
  dec_t                       dec;
  logic [QUO_W-1:0]           quotient;
  logic signed [VALUE_W-1:0]  scale_val;
  side_t                      side_q [1:DIV_STAGES];
  side_t                      side_last;
  logic signed [VALUE_W-1:0]  value_q, value_d;
  logic                       invalid_q;
  logic [7:0]                 ndiv_q;
  logic                       dwrite_q;

  // Take a write in any cycle; the user must write only while no request is in
  // flight (not enforced): decode and scale stages read ref_q at different times
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= REF_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ref_q <= cfg_data_i;
    end
  end

  // Stage valid bits and load enables
  hrc_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .en_o        (en),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // Stage 0: decode the request
  hrc_decode u_decode (
    .clk_i          (clk_i),
    .en_i           (en[0]),
    .command_i      (command_i),
    .channel_i      (channel_i),
    .raw_count_i    (raw_count_i),
    .divisor_byte_i (divisor_byte_i),
    .wide_count_i   (wide_count_i),
    .ref_mv_i       (ref_q),
    .dec_o          (dec)
  );

  // Stages 1..7: fan rpm division
  hrc_div u_div (
    .clk_i      (clk_i),
    .en_i       (en[DIV_STAGES:1]),
    .divisor_i  (dec.divisor),
    .quotient_o (quotient)
  );

  // Stages 1..7: temperature and voltage scaling, in step with the divider
  hrc_scale u_scale (
    .clk_i    (clk_i),
    .en_i     (en[DIV_STAGES:1]),
    .dec_i    (dec),
    .ref_mv_i (ref_q),
    .value_o  (scale_val)
  );

  // Carry the flags and divisor image alongside the arithmetic
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      side_q[1] <= '{is_fan:  dec.is_fan,  div_run: dec.div_run,
                     invalid: dec.invalid, ndiv:    dec.ndiv,
                     dwrite:  dec.dwrite};
    end
    for (int k = 2; k <= DIV_STAGES; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side_last = side_q[DIV_STAGES];

  // Pick the fan quotient or the scaled value; drop to zero when no divide ran
  always_comb begin
    if (side_last.is_fan) begin
      value_d = side_last.div_run ? $signed({{(VALUE_W-QUO_W){1'b0}}, quotient})
                                  : '0;
    end else begin
      value_d = scale_val;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk_i) begin
    if (en[NUM_STAGES-1]) begin
      value_q   <= value_d;
      invalid_q <= side_last.invalid;
      ndiv_q    <= side_last.ndiv;
      dwrite_q  <= side_last.dwrite;
    end
  end

  assign value_o            = value_q;
  assign invalid_o          = invalid_q;
  assign new_divisor_byte_o = ndiv_q;
  assign divisor_write_o    = dwrite_q;

endmodule

@@ tb/sv/hwmon_reading_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwmon_reading_checker
// Predicts each converted reading and compares it with the block's output.
// ----------------------------------------------------------------------------
module hwmon_reading_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [1:0]                         command_i,
  input  logic [3:0]                         channel_i,
  input  logic [15:0]                        raw_count_i,
  input  logic [7:0]                         divisor_byte_i,
  input  logic                               wide_count_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [hrc_pkg::VALUE_W-1:0] value_i,
  input  logic                               invalid_i,
  input  logic [7:0]                         new_divisor_byte_i,
  input  logic                               divisor_write_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [hrc_pkg::REF_W-1:0]          cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 checked_o
);
  import hrc_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      invalid;
    logic [7:0]                ndiv;
    logic                      dwrite;
  } reading_t;

  reading_t         expected_readings_q[$];
  logic [REF_W-1:0] reference_mv_q;

  // Resistor factor scaled by 10^4
  function automatic longint rail_factor(input logic [3:0] ch);
    case (ch)
      4'd3, 4'd7: return 16800;
      4'd4:       return 40000;
      4'd5:       return 31000;
      4'd6:       return 51500;
      default:    return 10000;
    endcase
  endfunction

  function automatic reading_t convert_reading(input cmd_e cmd, input logic [3:0] ch,
                                               input logic [15:0] raw,
                                               input logic [7:0] dvb, input logic wide,
                                               input logic [REF_W-1:0] ref_mv);
    reading_t    r;
    longint      v;
    logic        neg;
    logic [2:0]  shift;
    logic [15:0] cnt;
    logic [15:0] sat;
    logic [7:0]  lo;
    lo = raw[7:0];
    v = 0;
    r.invalid = 1'b0;
    r.ndiv = dvb;
    case (cmd)
      CMD_TEMP: v = longint'(lo) * 1000000 + 273150000;
      CMD_VOLT: begin
        if (ch <= 4'd8) begin
          neg = (ch == 4'd5) || (ch == 4'd6);
          v = longint'(lo) * 16;
          if (neg) v = v - longint'(ref_mv);
          v = (v * rail_factor(ch)) / 10;
          if (neg) v = v + longint'(ref_mv) * 1000;
        end
      end
      CMD_FAN8: begin
        if (ch <= 4'd2) begin
          if (lo == 8'hff) begin
            r.invalid = 1'b1;
            case (ch)
              4'd0:    r.ndiv = {dvb[7:3], dvb[2:0] + 3'd1};
              4'd1:    r.ndiv = {dvb[7:6], dvb[5:3] + 3'd1, dvb[2:0]};
              default: r.ndiv = dvb ^ 8'h40;
            endcase
          end else if (lo != 8'h00) begin
            if (ch == 4'd2) shift = dvb[6] ? 3'd3 : 3'd1;
            else if (ch == 4'd1) shift = dvb[5:3];
            else shift = dvb[2:0];
            v = 1350000 / (longint'(lo) << shift);
          end
        end
      end
      default: begin
        if (ch <= 4'd2) begin
          cnt = wide ? raw : {8'h00, lo};
          sat = wide ? 16'hffff : 16'h00ff;
          if (cnt == sat) r.invalid = 1'b1;
          else if (cnt != 16'h0000) v = 675000 / longint'(cnt);
        end
      end
    endcase
    r.value = v[VALUE_W-1:0];
    r.dwrite = (r.ndiv != dvb);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    reading_t got;
    if (!rst_ni) begin
      expected_readings_q.delete();
      reference_mv_q <= REF_RESET;
      fail_count_o   <= 0;
      pending_o      <= 0;
      checked_o      <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) reference_mv_q <= cfg_data_i;
      // Compare the accepted result with the oldest waiting expectation
      if (out_valid_i && !out_stall_i) begin
        got = '{value_i, invalid_i, new_divisor_byte_i, divisor_write_i};
        if (expected_readings_q.size() == 0) begin
          $display("%0t: result with no request outstanding: expected none, actual value %0d",
                   $time, got.value);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_readings_q.pop_front();
          checked_o <= checked_o + 1;
          if (got != want) begin
            fail_count_o <= fail_count_o + 1;
            if (got.value != want.value)
              $display("%0t: value mismatch: expected %0d, actual %0d",
                       $time, want.value, got.value);
            if (got.invalid != want.invalid)
              $display("%0t: invalid mismatch: expected %0b, actual %0b",
                       $time, want.invalid, got.invalid);
            if (got.ndiv != want.ndiv)
              $display("%0t: new divisor byte mismatch: expected %02h, actual %02h",
                       $time, want.ndiv, got.ndiv);
            if (got.dwrite != want.dwrite)
              $display("%0t: divisor write mismatch: expected %0b, actual %0b",
                       $time, want.dwrite, got.dwrite);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_readings_q.push_back(convert_reading(cmd_e'(command_i), channel_i,
                                                      raw_count_i, divisor_byte_i,
                                                      wide_count_i, reference_mv_q));
      pending_o <= expected_readings_q.size();
    end
  end

endmodule

@@ tb/sv/tb_hwmon_reading_converter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hwmon_reading_converter_top
// Drives directed and random sensor readings through the converter across
// several reference voltages, with random idling on both channels; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_hwmon_reading_converter_top;
  import hrc_pkg::*;

  localparam int PHASE_ITEMS = 130;
  localparam int NUM_PHASES  = 5;
  localparam int DRAIN_WAIT  = 20;

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                command_i = '0;
  logic [3:0]                channel_i = '0;
  logic [15:0]               raw_count_i = '0;
  logic [7:0]                divisor_byte_i = '0;
  logic                      wide_count_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [VALUE_W-1:0] value_o;
  logic                      invalid_o;
  logic [7:0]                new_divisor_byte_o;
  logic                      divisor_write_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [REF_W-1:0]          cfg_data_i = '0;

  int   fail_count;
  int   pending;
  int   checked;
  logic no_idle = 1'b0;           // set during the stretch without idling
  int   requests_per_cmd[4];
  int   ref_writes;

  hwmon_reading_converter_top i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .channel_i          (channel_i),
    .raw_count_i        (raw_count_i),
    .divisor_byte_i     (divisor_byte_i),
    .wide_count_i       (wide_count_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .value_o            (value_o),
    .invalid_o          (invalid_o),
    .new_divisor_byte_o (new_divisor_byte_o),
    .divisor_write_o    (divisor_write_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i)
  );

  hwmon_reading_checker i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .command_i          (command_i),
    .channel_i          (channel_i),
    .raw_count_i        (raw_count_i),
    .divisor_byte_i     (divisor_byte_i),
    .wide_count_i       (wide_count_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .value_i            (value_o),
    .invalid_i          (invalid_o),
    .new_divisor_byte_i (new_divisor_byte_o),
    .divisor_write_i    (divisor_write_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .checked_o          (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stall the result channel about one cycle in five, except in the quiet stretch
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && !no_idle && ($urandom_range(0, 99) < 20);
  end

  // Present one request, idling first at random, and hold it until accepted.
  // Sample the stall at the falling edge so the decision never races the block.
  task automatic send_request(input cmd_e cmd, input logic [3:0] ch,
                              input logic [15:0] raw, input logic [7:0] dvb,
                              input logic wide);
    logic go;
    if (!no_idle && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 40);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    channel_i      <= ch;
    raw_count_i    <= raw;
    divisor_byte_i <= dvb;
    wide_count_i   <= wide;
    do begin
      @(negedge clk_i);
      go = !in_stall_o;
      @(posedge clk_i);
    end while (!go);
    requests_per_cmd[cmd]++;
  endtask

  // Drop valid and hold until every predicted result has come back; the
  // extra edge lets the count see the request accepted at this edge
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Write the reference voltage; only called while the pipeline is empty
  task automatic write_reference(input logic [REF_W-1:0] mv);
    logic go;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mv;
    do begin
      @(negedge clk_i);
      go = cfg_ready_o;
      @(posedge clk_i);
    end while (!go);
    cfg_valid_i <= 1'b0;
    ref_writes++;
  endtask

  // Random request: mostly in-range channels, with saturated and zero counts boosted
  task automatic random_request();
    cmd_e        cmd;
    logic [3:0]  ch;
    logic [15:0] raw;
    int          pick;
    cmd = cmd_e'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) ch = 4'($urandom_range(0, 15));
    else if (cmd == CMD_VOLT) ch = 4'($urandom_range(0, 8));
    else ch = 4'($urandom_range(0, 2));
    pick = $urandom_range(0, 99);
    raw = 16'($urandom);
    if (pick < 15) raw[7:0] = 8'hff;
    else if (pick < 25) raw = 16'hffff;
    else if (pick < 33) raw[7:0] = 8'h00;
    else if (pick < 38) raw = 16'h0000;
    send_request(cmd, ch, raw, 8'($urandom), 1'($urandom));
  endtask

  initial begin
    logic [REF_W-1:0] phase_ref[NUM_PHASES];
    phase_ref = '{13'd0, 13'd8191, 13'($urandom), 13'd1, 13'($urandom)};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the reset reference voltage
    send_request(CMD_TEMP, 4'd0, 16'h0000, 8'h00, 1'b0);
    send_request(CMD_TEMP, 4'd15, 16'hffff, 8'hff, 1'b1);   // high byte ignored
    for (int ch = 0; ch <= 8; ch++)
      send_request(CMD_VOLT, 4'(ch), 16'(ch * 29 + 3), 8'h00, 1'b0);
    send_request(CMD_VOLT, 4'd5, 16'h0000, 8'h00, 1'b0);      // negative rail, raw below ref
    send_request(CMD_VOLT, 4'd6, 16'hffff, 8'h00, 1'b0);
    send_request(CMD_VOLT, 4'd9, 16'h0080, 8'h00, 1'b0);      // out-of-range voltage channel
    send_request(CMD_FAN8, 4'd0, 16'h00ff, 8'h07, 1'b0);      // saturated, field wraps
    send_request(CMD_FAN8, 4'd1, 16'hffff, 8'h38, 1'b0);      // saturated, field wraps
    send_request(CMD_FAN8, 4'd2, 16'h00ff, 8'h40, 1'b0);      // saturated, bit toggles
    send_request(CMD_FAN8, 4'd0, 16'h0000, 8'hff, 1'b0);      // zero count
    send_request(CMD_FAN8, 4'd1, 16'h0001, 8'h00, 1'b0);      // largest rpm
    send_request(CMD_FAN8, 4'd0, 16'h00fe, 8'h07, 1'b0);      // widest shift
    send_request(CMD_FAN8, 4'd15, 16'h00ff, 8'hff, 1'b0);     // out-of-range fan
    send_request(CMD_FAN16, 4'd2, 16'hffff, 8'h5a, 1'b1);     // wide, saturated
    send_request(CMD_FAN16, 4'd0, 16'h0100, 8'h00, 1'b1);     // wide, low byte zero
    send_request(CMD_FAN16, 4'd1, 16'h12ff, 8'h00, 1'b0);     // narrow, saturated
    send_request(CMD_FAN16, 4'd3, 16'h0001, 8'h00, 1'b1);     // out-of-range fan
    drain_results();

    // Random phases, each at its own reference voltage; phase 2 runs without idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reference(phase_ref[p]);
      no_idle <= (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) random_request();
      drain_results();
    end
    no_idle <= 1'b0;

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Sent %0d temperature, %0d voltage, %0d 8-bit fan and %0d 16-bit fan requests",
             requests_per_cmd[CMD_TEMP], requests_per_cmd[CMD_VOLT],
             requests_per_cmd[CMD_FAN8], requests_per_cmd[CMD_FAN16]);
    $display("over %0d reference voltage writes; %0d results checked", ref_writes, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("hwmon_reading_converter_top regression: pass");
    end else begin
      $display("hwmon_reading_converter_top regression: fail");
    end
    $finish;
  end

  // Bound the run well beyond the slowest correct case
  initial begin
    #1000000;
    $display("Timeout with %0d results outstanding", pending);
    $display("hwmon_reading_converter_top regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
rtl/hrc_pkg.sv
rtl/hrc_flow.sv
rtl/hrc_decode.sv
rtl/hrc_div.sv
rtl/hrc_scale.sv
rtl/hwmon_reading_converter_top.sv
tb/sv/hwmon_reading_checker.sv
tb/sv/tb_hwmon_reading_converter_top.sv
